FILE: rtl/text_console_cursor_scroll_defines.svh
// Assertion macros for the text console engine.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define TCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCCS_ASSERT(lbl, prop, msg)
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/tccs_pkg.sv
// Shared constants for the text console engine.
`default_nettype none

package tccs_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned CELL_W  = CHAR_W + ATTR_W;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_FG     = 1'b0;
  localparam logic        REG_BG     = 1'b1;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  // Opcodes and character codes
  localparam logic              OP_PUT       = 1'b0;
  localparam logic              OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

endpackage

`default_nettype wire

FILE: rtl/tccs_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_scroll.sv
// Text console engine: cursor, character cell store and scroll sequencer.
`default_nettype none
`include "text_console_cursor_scroll_defines.svh"

// After reset the engine clears its 2000-cell store, one cell a cycle, and
// holds busy high while it does so; configuration writes are taken at
// any time. An item is taken when start is high and busy is low. A put
// (character or newline that needs no scroll) gives its result in the
// cycle after the transfer and leaves busy low, so puts can follow every
// cycle. A read gives its result after the store's registered read port and
// the ST_READ state. A put that moves past the bottom row scrolls: the store
// is copied up a row and the last row blanked through the store's read port
// and its write port, one cell a cycle, and then ST_FLUSH gives the result.
// Each result is on the ports for exactly one cycle with done_o high; the
// receiver cannot stall it and must take it then.
module text_console_cursor_scroll (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tccs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tccs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tccs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  // command
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode_i,
  input  wire logic [tccs_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic [tccs_pkg::COL_W-1:0]       read_col_i,
  input  wire logic [tccs_pkg::ROW_W-1:0]       read_row_i,
  // result
  output logic                                  done_o,
  output logic      [tccs_pkg::COL_W-1:0]       cursor_col_o,
  output logic      [tccs_pkg::ROW_W-1:0]       cursor_row_o,
  output logic                                  scrolled_o,
  output logic      [tccs_pkg::CHAR_W-1:0]      cell_char_o,
  output logic      [tccs_pkg::ATTR_W-1:0]      cell_attribute_o
);

  import tccs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FLUSH
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                done_q, done_d;
  logic                scrolled_q, scrolled_d;
  logic [CHAR_W-1:0]   cchar_q, cchar_d;
  logic [ATTR_W-1:0]   cattr_q, cattr_d;
  logic                in_range_q, in_range_d;
  logic                wr_vld_q, wr_vld_d;
  logic [ADDR_W-1:0]   wr_addr_q, wr_addr_d;
  logic                wr_blank_q, wr_blank_d;
  logic [COLOR_W-1:0]  fg_q, bg_q;

  logic                accept;
  logic                cfg_write;
  logic [ATTR_W-1:0]   attr;
  logic [CELL_W-1:0]   blank_cell;
  logic [ADDR_W-1:0]   cursor_addr;
  logic [ADDR_W-1:0]   read_addr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign attr       = {bg_q, fg_q};
  assign blank_cell = {attr, SPACE_CODE};
  assign cursor_addr = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
  assign read_addr   = ADDR_W'(int'(read_row_i) * COLUMNS + int'(read_col_i));

  // Configuration registers: write on the access phase, read back always
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FG:  fg_q <= pwdata[COLOR_W-1:0];
        REG_BG:  bg_q <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FG:  prdata = CFG_DATA_W'(fg_q);
      REG_BG:  prdata = CFG_DATA_W'(bg_q);
      default: prdata = '0;
    endcase
  end

  // Store port selection: clear sweep, cursor write, or scroll copy
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_addr;
    ram_wdata = {attr, char_code_i};
    ram_raddr = read_addr;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_we = accept && (opcode_i == OP_PUT) && (char_code_i != NEWLINE_CODE);
      end
      ST_SCROLL, ST_FLUSH: begin
        ram_we    = wr_vld_q;
        ram_waddr = wr_addr_q;
        ram_wdata = wr_blank_q ? blank_cell : ram_rdata;
        ram_raddr = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
      end
      default: ;
    endcase
  end

  // Sequencer: next state, cursor and result
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    done_d     = 1'b0;
    scrolled_d = scrolled_q;
    cchar_d    = cchar_q;
    cattr_d    = cattr_q;
    in_range_d = in_range_q;
    wr_vld_d   = 1'b0;
    wr_addr_d  = cnt_q;
    wr_blank_d = (cnt_q >= ADDR_W'((ROWS - 1) * COLUMNS));
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_READ) begin
            in_range_d = (int'(read_col_i) < COLUMNS) && (int'(read_row_i) < ROWS);
            state_d    = ST_READ;
          end else begin
            cchar_d    = '0;
            cattr_d    = '0;
            scrolled_d = 1'b0;
            if ((char_code_i != NEWLINE_CODE) && (int'(col_q) < COLUMNS - 1)) begin
              // Advance along the row
              col_d  = col_q + 1'b1;
              done_d = 1'b1;
            end else begin
              // Start a new row, scrolling at the bottom
              col_d = '0;
              if (int'(row_q) < ROWS - 1) begin
                row_d  = row_q + 1'b1;
                done_d = 1'b1;
              end else begin
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end
            end
          end
        end
      end
      ST_READ: begin
        cchar_d    = in_range_q ? ram_rdata[CHAR_W-1:0] : '0;
        cattr_d    = in_range_q ? ram_rdata[CELL_W-1:CHAR_W] : '0;
        scrolled_d = 1'b0;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one row ahead, write back in the next cycle
        wr_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        scrolled_d = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      done_q     <= 1'b0;
      scrolled_q <= 1'b0;
      cchar_q    <= '0;
      cattr_q    <= '0;
      in_range_q <= 1'b0;
      wr_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      done_q     <= done_d;
      scrolled_q <= scrolled_d;
      cchar_q    <= cchar_d;
      cattr_q    <= cattr_d;
      in_range_q <= in_range_d;
      wr_vld_q   <= wr_vld_d;
    end
  end

  // Scroll write pipeline payload
  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    wr_blank_q <= wr_blank_d;
  end

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o           = done_q;
  assign cursor_col_o     = col_q;
  assign cursor_row_o     = row_q;
  assign scrolled_o       = scrolled_q;
  assign cell_char_o      = cchar_q;
  assign cell_attribute_o = cattr_q;

  // A result never lands while the sequencer is still working
  `TCCS_ASSERT(a_done_idle, !done_o || !busy, "result strobe while busy")
  // A scroll leaves the cursor at the start of the bottom row
  `TCCS_ASSERT(a_scroll_cursor,
    !(done_o && scrolled_o) || ((int'(cursor_row_o) == ROWS - 1) && (cursor_col_o == '0)),
    "scroll left cursor off the bottom row start")
  // The cursor stays inside the screen
  `TCCS_ASSERT(a_cursor_range,
    (int'(cursor_col_o) < COLUMNS) && (int'(cursor_row_o) < ROWS),
    "cursor outside the screen")
  // A read is not answered straight away: once it is taken the engine is busy and done_o is low
  `TCCS_ASSERT_NEXT(a_read_lat, accept && (opcode_i == OP_READ), !done_o && busy,
    "read finished too early")

endmodule

`default_nettype wire
